>>> hdl/sync_pulse_tempo_detector_defines.svh
// Assertion macros for the sync pulse tempo detector.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef SYNC_PULSE_TEMPO_DETECTOR_DEFINES_SVH
`define SYNC_PULSE_TEMPO_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/spt_pkg.sv
// Shared types and constants of the sync pulse tempo detector.
// No dependencies; imported by every module of the block.
package spt_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int TIME_BITS     = 32;
    localparam int THR_BITS      = 15;
    localparam int TEMPO_BITS    = 8;
    localparam int CFG_DATA_BITS = 15;
    localparam int CFG_IDX_BITS  = 2;

    // Width that holds a sample, the threshold and their difference as signed values.
    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS + 1 : THR_BITS + 1;

    // Microseconds per minute, the dividend of the tempo divide.
    localparam int                US_BITS       = 26;
    localparam logic [US_BITS-1:0] US_PER_MINUTE = US_BITS'(60000000);
    localparam int                DIV_CNT_BITS  = $clog2(US_BITS);

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = $clog2(QDEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_FLOOR     = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] CFG_CEILING   = CFG_IDX_BITS'(2);

    localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(6554);
    localparam logic [TEMPO_BITS-1:0] FLOOR_RESET = TEMPO_BITS'(30);
    localparam logic [TEMPO_BITS-1:0] CEIL_RESET  = TEMPO_BITS'(240);
    localparam logic [TEMPO_BITS-1:0] TEMPO_RESET = TEMPO_BITS'(120);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sync_sample;
        logic [TIME_BITS-1:0]          now_us;
    } t_in;

    typedef struct packed {
        logic [TEMPO_BITS-1:0] tempo_bpm;
        logic                  edge_seen;
        logic                  tempo_updated;
    } t_out;

    typedef struct packed {
        logic [THR_BITS-1:0]   threshold;
        logic [TEMPO_BITS-1:0] tempo_floor;
        logic [TEMPO_BITS-1:0] tempo_ceiling;
    } t_cfg;

    // One classified sample on its way to the tempo unit.
    typedef struct packed {
        logic                 edge_seen;
        logic                 div_go;
        logic [TIME_BITS-1:0] elapsed;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hdl/sync_pulse_tempo_detector.sv
// Top level of the sync pulse tempo detector: configuration registers,
// front end, job queue and tempo unit. Depends on spt_pkg and the defines header.
`include "sync_pulse_tempo_detector_defines.svh"

// Each sync sample beat yields one result beat carrying the current tempo,
// an edge flag and a tempo-accepted flag. A sample that forms no timed edge
// passes through the queue and the result register. A rising edge with a
// nonzero interval since the previous edge goes through the tempo unit: it
// picks up the job, runs the restoring divide of 60000000 by the interval
// (one quotient bit per cycle), rounds and halves, then checks the tempo
// window. A two-entry queue lets the sample input keep taking beats while a
// divide is in progress. Configuration writes take effect at the next clock
// and should be issued only while the block is idle.
module sync_pulse_tempo_detector
    import spt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in                      i_in,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out                     o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_job    push_job, head_job;
    t_q_stat q_stat;
    logic    push, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= THR_RESET;
            r_cfg.tempo_floor   <= FLOOR_RESET;
            r_cfg.tempo_ceiling <= CEIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_cfg.threshold     <= i_cfg_data[THR_BITS-1:0];
                CFG_FLOOR:     r_cfg.tempo_floor   <= i_cfg_data[TEMPO_BITS-1:0];
                CFG_CEILING:   r_cfg.tempo_ceiling <= i_cfg_data[TEMPO_BITS-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    spt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (push_job)
    );

    spt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_stat  (q_stat)
    );

    spt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // An accepted tempo always comes from an edge.
    `SPT_ASSERT_IMP(a_update_needs_edge, o_out_valid && o_out.tempo_updated, o_out.edge_seen, "tempo update without edge")

    // An accepted tempo lies inside the configured window.
    `SPT_ASSERT_IMP(a_update_in_window, o_out_valid && o_out.tempo_updated, (o_out.tempo_bpm >= r_cfg.tempo_floor) && (o_out.tempo_bpm <= r_cfg.tempo_ceiling), "accepted tempo outside window")

    // A beat taken into an empty queue is held there on the next cycle.
    `SPT_ASSERT_NXT(a_push_lands, i_in_valid && o_in_ready && q_stat.empty, !q_stat.empty, "accepted sample lost in queue")

endmodule

>>> hdl/spt_front.sv
// Front end: accepts sync samples, tracks the cached level and edge time,
// and classifies each sample into a job. Depends on spt_pkg.
module spt_front
    import spt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_in     i_in,
    input  t_cfg    i_cfg,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_job    o_job
);

    logic signed [SAMPLE_BITS-1:0] r_cached, n_cached;
    logic [TIME_BITS-1:0]          r_last_time, n_last_time;

    logic signed [CMP_BITS-1:0] s_ext, c_ext, thr_ext, diff, diff_abs;
    logic                       moved, rising;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        s_ext    = CMP_BITS'(i_in.sync_sample);
        c_ext    = CMP_BITS'(r_cached);
        thr_ext  = signed'(CMP_BITS'(i_cfg.threshold));
        diff     = s_ext - c_ext;
        diff_abs = (diff < 0) ? -diff : diff;
        moved    = diff_abs > thr_ext;
        rising   = moved && (c_ext < thr_ext) && (s_ext > thr_ext);

        o_job.edge_seen = rising;
        o_job.elapsed   = i_in.now_us - r_last_time;
        o_job.div_go    = rising && (o_job.elapsed != '0);

        n_cached    = (o_push && moved)  ? i_in.sync_sample : r_cached;
        n_last_time = (o_push && rising) ? i_in.now_us      : r_last_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached    <= '0;
            r_last_time <= '0;
        end else begin
            r_cached    <= n_cached;
            r_last_time <= n_last_time;
        end
    end

endmodule

>>> hdl/spt_queue.sv
// Short job queue between the front end and the tempo unit.
// Depends on spt_pkg for the job type and depth.
module spt_queue
    import spt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_head,
    output t_q_stat o_stat
);

    t_job                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr, r_rd;
    logic [QPTR_BITS:0]   r_count;

    assign o_stat.full  = (r_count == (QPTR_BITS + 1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/spt_back.sv
// Tempo unit: takes jobs from the queue, divides the minute by the edge
// interval one quotient bit per cycle, and drives the result register.
// Depends on spt_pkg.
module spt_back
    import spt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_job    i_head,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RND,
        S_FIN
    } t_state;

    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;
    logic [TEMPO_BITS-1:0]   r_tempo, n_tempo;
    logic [TIME_BITS-1:0]    r_div, n_div;
    logic [TIME_BITS-1:0]    r_rem, n_rem;
    logic [US_BITS-1:0]      r_quo, n_quo;
    logic [DIV_CNT_BITS-1:0] r_cnt, n_cnt;

    logic                 out_free;
    logic [TIME_BITS:0]   trial;
    logic                 round_up;
    logic                 in_range;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_tempo     = r_tempo;
        n_div       = r_div;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        o_pop       = 1'b0;

        trial    = {r_rem, US_PER_MINUTE[r_cnt]};
        round_up = {r_rem, 1'b0} >= {1'b0, r_div};
        in_range = (r_quo >= US_BITS'(i_cfg.tempo_floor))
                && (r_quo <= US_BITS'(i_cfg.tempo_ceiling));

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_head.div_go) begin
                        n_div   = i_head.elapsed;
                        n_rem   = '0;
                        n_quo   = '0;
                        n_cnt   = DIV_CNT_BITS'(US_BITS - 1);
                        n_state = S_DIV;
                    end else begin
                        n_out_valid         = 1'b1;
                        n_out.tempo_bpm     = r_tempo;
                        n_out.edge_seen     = i_head.edge_seen;
                        n_out.tempo_updated = 1'b0;
                    end
                end
            end
            S_DIV: begin
                // Restoring divide: the partial remainder always stays below the divisor.
                if (trial >= {1'b0, r_div}) begin
                    n_rem = TIME_BITS'(trial - {1'b0, r_div});
                    n_quo = {r_quo[US_BITS-2:0], 1'b1};
                end else begin
                    n_rem = trial[TIME_BITS-1:0];
                    n_quo = {r_quo[US_BITS-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                // Round to nearest with ties up, then halve; r_quo now holds the tempo.
                n_quo   = (r_quo + US_BITS'(round_up)) >> 1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.edge_seen     = 1'b1;
                    n_out.tempo_updated = in_range;
                    if (in_range) begin
                        n_tempo         = r_quo[TEMPO_BITS-1:0];
                        n_out.tempo_bpm = r_quo[TEMPO_BITS-1:0];
                    end else begin
                        n_out.tempo_bpm = r_tempo;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tempo     <= TEMPO_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tempo     <= n_tempo;
        end
        r_out <= n_out;
        r_div <= n_div;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

endmodule

>>> test/tb_sync_pulse_tempo_detector.sv
// Self-checking testbench of sync_pulse_tempo_detector: directed corners, pulse trains
// and noise under several threshold and tempo window settings. Depends on spt_pkg.
module tb_sync_pulse_tempo_detector
    import spt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    t_in                      i_in       = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out                     o_out;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    sync_pulse_tempo_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Register settings as the block holds them.
    logic [THR_BITS-1:0]   thr_now   = THR_RESET;
    logic [TEMPO_BITS-1:0] floor_now = FLOOR_RESET;
    logic [TEMPO_BITS-1:0] ceil_now  = CEIL_RESET;

    // Predicted detector state.
    int                    level_now = 0;
    logic [TIME_BITS-1:0]  edge_us   = '0;
    logic [TEMPO_BITS-1:0] tempo_now = TEMPO_RESET;

    t_in  sample_queue [$];
    t_out tempo_due [$];
    int   fail_count = 0;
    bit   gaps_on    = 1'b1;

    // Stimulus generator state.
    int unsigned beat_us     = 0;
    int          last_high   = 32767;
    int unsigned beats_queued = 0;

    int corner_smp [20] = '{6554, 6555, -32768, 32767, -32768, 32767, -32768, 32767,
                            -32768, 32767, 0, 32767, 0, 6555, -1, 32767, -32768, 32767,
                            -32768, 32767};
    int unsigned corner_us [20] = '{100, 500000, 500010, 500000, 0, 625000, 700000,
                                    1625000, 1625001, 2659483, 2700000, 2784482, 2800000,
                                    2908482, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0, 39999999, 5,
                                    40000000};

    function automatic void track_sync_beat(input t_in beat);
        int                smp;
        int                thr;
        int                delta;
        logic [TIME_BITS-1:0] elapsed;
        longint unsigned   quot;
        longint unsigned   rem;
        longint unsigned   bpm;
        t_out              res;
        smp = int'($signed(beat.sync_sample));
        thr = int'(thr_now);
        delta = smp - level_now;
        if (delta < 0) begin
            delta = -delta;
        end
        res = '0;
        if (delta > thr) begin
            if (level_now < thr && smp > thr) begin
                res.edge_seen = 1'b1;
                elapsed = beat.now_us - edge_us;
                if (elapsed != '0) begin
                    quot = 64'd60000000 / elapsed;
                    rem  = 64'd60000000 % elapsed;
                    // Round to nearest with ties up, then halve with truncation.
                    if (2 * rem >= elapsed) begin
                        quot = quot + 1;
                    end
                    bpm = quot >> 1;
                    if (bpm >= floor_now && bpm <= ceil_now) begin
                        tempo_now = bpm[TEMPO_BITS-1:0];
                        res.tempo_updated = 1'b1;
                    end
                end
                edge_us = beat.now_us;
            end
            level_now = smp;
        end
        res.tempo_bpm = tempo_now;
        tempo_due.insert(tempo_due.size(), res);
    endfunction

    function automatic void queue_beat(input int smp, input int unsigned stamp);
        t_in beat;
        beat.sync_sample = smp[SAMPLE_BITS-1:0];
        beat.now_us = stamp;
        sample_queue.insert(sample_queue.size(), beat);
        beats_queued++;
    endfunction

    // Time between pulses: mostly inside the usual tempo window, with exact
    // window edges, a tie in the rounding, zero, one and arbitrary intervals.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 75) begin
            return $urandom_range(1100000, 110000);
        end else if (roll < 87) begin
            case ($urandom_range(5))
                0: return 0;
                1: return 1;
                2: return 40000000;
                3: return 125000;
                4: return 1000000;
                default: return 124999;
            endcase
        end else if (roll < 93) begin
            return $urandom_range(300000, 20000);
        end
        return $urandom;
    endfunction

    task automatic queue_random(input int unsigned count);
        int unsigned goal;
        int unsigned roll;
        int unsigned gap;
        int          thr;
        int          lo_top;
        int          hi_bottom;
        int          low;
        int          lows;
        goal = beats_queued + count;
        while (beats_queued < goal) begin
            roll = $urandom_range(99);
            thr = int'(thr_now);
            if (roll < 70 && thr < 32767) begin
                // A well-formed pulse: one or more samples well below the
                // threshold, then one that rises clearly above it.
                gap = pick_gap();
                lo_top = thr - 1;
                if (last_high - thr - 1 < lo_top) begin
                    lo_top = last_high - thr - 1;
                end
                if (32766 - thr < lo_top) begin
                    lo_top = 32766 - thr;
                end
                hi_bottom = thr + 1;
                lows = $urandom_range(3, 1);
                for (int k = 0; k < lows; k++) begin
                    low = -32768 + int'($urandom_range(lo_top + 32768));
                    if (low + thr + 1 > hi_bottom) begin
                        hi_bottom = low + thr + 1;
                    end
                    queue_beat(low, beat_us + $urandom_range(gap));
                end
                last_high = hi_bottom + int'($urandom_range(32767 - hi_bottom));
                beat_us = beat_us + gap;
                queue_beat(last_high, beat_us);
            end else if (roll < 85) begin
                if ($urandom_range(3) == 0) begin
                    queue_beat(int'($urandom_range(65535)) - 32768, $urandom);
                end else begin
                    queue_beat(int'($urandom_range(65535)) - 32768,
                               beat_us + $urandom_range(2000000));
                end
            end else begin
                // Samples right at the threshold, stamped with the last edge time.
                queue_beat(thr + int'($urandom_range(2)) - 1, beat_us);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_BITS'(value);
        case (idx)
            CFG_THRESHOLD: thr_now   = THR_BITS'(value);
            CFG_FLOOR:     floor_now = TEMPO_BITS'(value);
            CFG_CEILING:   ceil_now  = TEMPO_BITS'(value);
            default: ;
        endcase
    endtask

    task automatic set_window(input int unsigned thr, input int unsigned lo,
                              input int unsigned hi);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_FLOOR, lo);
        write_reg(CFG_CEILING, hi);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || tempo_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_sync_beat(i_in);
            end
            if (!i_in_valid || o_in_ready) begin
                if (sample_queue.size() != 0 && !(gaps_on && $urandom_range(99) < 30)) begin
                    i_in       <= sample_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (tempo_due.size() == 0) begin
                    $display("%0t: result beat with none pending: %p", $time, o_out);
                    fail_count++;
                end else begin
                    want = tempo_due.pop_front();
                    if (o_out.tempo_bpm !== want.tempo_bpm) begin
                        $display("%0t: tempo_bpm expected %0d, got %0d",
                                 $time, want.tempo_bpm, o_out.tempo_bpm);
                        fail_count++;
                    end
                    if (o_out.edge_seen !== want.edge_seen) begin
                        $display("%0t: edge_seen expected %0b, got %0b",
                                 $time, want.edge_seen, o_out.edge_seen);
                        fail_count++;
                    end
                    if (o_out.tempo_updated !== want.tempo_updated) begin
                        $display("%0t: tempo_updated expected %0b, got %0b",
                                 $time, want.tempo_updated, o_out.tempo_updated);
                        fail_count++;
                    end
                end
            end
            i_out_ready <= !(gaps_on && $urandom_range(99) < 30);
        end
    end

    initial begin
        #6000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 20; k++) begin
            queue_beat(corner_smp[k], corner_us[k]);
        end
        beat_us = corner_us[19];
        queue_random(400);
        wait_drained();

        // Window from 1 to 255 and zero threshold, run without any gaps on either side.
        set_window(0, 1, 255);
        gaps_on = 1'b0;
        queue_random(300);
        wait_drained();
        gaps_on = 1'b1;

        // Nothing can rise above the largest threshold.
        set_window(32767, 255, 255);
        queue_random(60);
        wait_drained();

        // Floor above ceiling rejects every tempo.
        set_window(16384, 200, 50);
        queue_random(200);
        wait_drained();

        repeat (4) begin
            set_window($urandom_range(20000), $urandom_range(255, 1), $urandom_range(255, 1));
            queue_random(200);
            wait_drained();
        end

        set_window(THR_RESET, FLOOR_RESET, CEIL_RESET);
        queue_random(100);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spt_pkg.sv
hdl/spt_front.sv
hdl/spt_queue.sv
hdl/spt_back.sv
hdl/sync_pulse_tempo_detector.sv
test/tb_sync_pulse_tempo_detector.sv
